// File: design/mwo_pkg.sv
`default_nettype none

package mwo_pkg;

	// Default build-time sizes.
	localparam int DEF_SINE_TABLE_BITS = 10;
	localparam int DEF_PHASE_BITS      = 32;

	// Field and register widths.
	localparam int INDEX_W  = 32;
	localparam int FREQ_W   = 24;
	localparam int MULT_W   = 21;
	localparam int OFFS_W   = 20;
	localparam int VOL_W    = 19;
	localparam int OUT_W    = 20;
	localparam int PERIOD_W = 41;
	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 24;

	// Wave amplitude: +1.0 in Q.16 and the width of a magnitude that holds it.
	localparam int ONE_Q16 = 65536;
	localparam int MAG_W   = 17;
	localparam int WAVE_W  = 18;

	// Saturation limits.
	localparam logic [MULT_W-1:0]   MULT_MAX   = MULT_W'(1310720);
	localparam logic [OFFS_W-1:0]   OFFSET_MAX = OFFS_W'(524288);
	localparam logic [VOL_W-1:0]    VOLUME_MAX = VOL_W'(262144);
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(64'd1099511627776);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(22906492);

	// Quarter turn in radians, Q30.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_TRIANGLE = 2'd1,
		WAVE_SAW      = 2'd2,
		WAVE_SQUARE   = 2'd3
	} wave_mode_t;

	typedef enum logic [0:0] {
		REG_WAVE_MODE     = 1'b0,
		REG_SAMPLE_PERIOD = 1'b1
	} reg_index_t;

	// One Taylor step: t * x^2, with Q30 rescaling after each product.
	function automatic logic [63:0] taylor_pow(input logic [63:0] t, input logic [63:0] x);
		taylor_pow = (((t * x) >> 30) * x) >> 30;
	endfunction

	// Entry k of the quarter-wave sine table, Q.16, capped at +1.0.
	function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
			input int unsigned bits);
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		longint      r;
		x    = (HALF_PI_Q30 * 64'(k)) >> bits;
		sum  = longint'(x);
		term = taylor_pow(x, x) / 64'd6;
		sum  = sum - longint'(term);
		term = taylor_pow(term, x) / 64'd20;
		sum  = sum + longint'(term);
		term = taylor_pow(term, x) / 64'd42;
		sum  = sum - longint'(term);
		term = taylor_pow(term, x) / 64'd72;
		sum  = sum + longint'(term);
		term = taylor_pow(term, x) / 64'd110;
		sum  = sum - longint'(term);
		term = taylor_pow(term, x) / 64'd156;
		sum  = sum + longint'(term);
		term = taylor_pow(term, x) / 64'd210;
		sum  = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		r = (sum + 8192) >>> 14;
		if (r > ONE_Q16) begin
			r = ONE_Q16;
		end
		sine_entry = MAG_W'(r);
	endfunction

endpackage

`default_nettype wire

// File: design/multi_waveform_oscillator.sv
// An input transaction passes through registered stages s1 to s8 before its result reaches the output port.
// One sample per clock while the output is ready; every item takes one slot of the eight-stage pipeline.
// A stalled output holds each full stage with no empty stage after it; the others keep advancing behind it.
// Reset (arst_n low) clears all pipeline valid bits, sets wave_mode to sine and
// sample_period to 22906492. The sine table is a constant ROM and needs no fill.
`default_nettype none

module multi_waveform_oscillator import mwo_pkg::*; #(
	parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
	parameter int PHASE_BITS      = DEF_PHASE_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [0:0]             cfg_index,
	input  wire logic [PERIOD_W-1:0]    cfg_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// sample_index[31:0], note_frequency[55:32], freq_multiplier[76:56],
	// phase_offset[96:77], volume[115:97], zero fill [119:116]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// sample_out[19:0], zero fill [23:20]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int SINE_N = 1 << SINE_TABLE_BITS;
	localparam int ADDR_W = SINE_TABLE_BITS + 1;
	localparam logic [ADDR_W-1:0] SINE_N_A = ADDR_W'(SINE_N);
	localparam logic [PHASE_BITS:0] FULL_TURN = (PHASE_BITS+1)'(1) << PHASE_BITS;

	typedef logic [MAG_W-1:0] rom_t [SINE_N+1];

	function automatic rom_t build_rom();
		rom_t t;
		for (int k = 0; k <= SINE_N; k++) begin
			t[k] = sine_entry(k, SINE_TABLE_BITS);
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Configuration registers.
	wave_mode_t          mode_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] period_wr;

	// Out-of-range periods are clamped when written.
	always_comb begin
		if (cfg_data == '0) begin
			period_wr = PERIOD_W'(1);
		end else if (cfg_data > PERIOD_MAX) begin
			period_wr = PERIOD_MAX;
		end else begin
			period_wr = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= WAVE_SINE;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_WAVE_MODE:     mode_q   <= wave_mode_t'(cfg_data[1:0]);
				REG_SAMPLE_PERIOD: period_q <= period_wr;
				default:           ;
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its successor loads.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	assign en_s8 = !v_s8 || m_axis_tready;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;
	assign m_axis_tvalid = v_s8;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	// Stage 1: unpack, saturate, and form the first partial products.
	logic [INDEX_W-1:0] in_idx;
	logic [FREQ_W-1:0]  in_freq;
	logic [MULT_W-1:0]  in_mult, mult_sat;
	logic [OFFS_W-1:0]  in_offs, offs_sat;
	logic [VOL_W-1:0]   in_vol, vol_sat;
	logic [44:0]        fm_c;
	logic [63:0]        iplo_c;
	logic [31:0]        iphi_c;

	assign in_idx  = s_axis_tdata[31:0];
	assign in_freq = s_axis_tdata[55:32];
	assign in_mult = s_axis_tdata[76:56];
	assign in_offs = s_axis_tdata[96:77];
	assign in_vol  = s_axis_tdata[115:97];

	assign mult_sat = (in_mult > MULT_MAX) ? MULT_MAX : in_mult;
	assign offs_sat = (in_offs > OFFSET_MAX) ? OFFSET_MAX : in_offs;
	assign vol_sat  = (in_vol > VOLUME_MAX) ? VOLUME_MAX : in_vol;
	assign fm_c   = 45'(in_freq) * 45'(mult_sat);
	assign iplo_c = 64'(in_idx) * 64'(period_q[31:0]);
	assign iphi_c = in_idx * {23'b0, period_q[40:32]};

	logic [44:0]      fm_s1, fm_s2;
	logic [63:0]      iplo_s1;
	logic [31:0]      iphi_s1;
	logic [15:0]      offs_s1, offs_s2, offs_s3;
	logic [VOL_W-1:0] vol_s1, vol_s2, vol_s3, vol_s4, vol_s5, vol_s6;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			fm_s1   <= fm_c;
			iplo_s1 <= iplo_c;
			iphi_s1 <= iphi_c;
			offs_s1 <= offs_sat[15:0];
			vol_s1  <= vol_sat;
		end
	end

	// Stage 2: index times period, modulo 2^64.
	logic [63:0] ip_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ip_s2   <= iplo_s1 + {iphi_s1, 32'b0};
			fm_s2   <= fm_s1;
			offs_s2 <= offs_s1;
			vol_s2  <= vol_s1;
		end
	end

	// Stage 3: partial products of (index*period) * (frequency*multiplier).
	logic [63:0] pll_c;
	logic [31:0] plh_c, phl_c;
	logic [63:0] pll_s3;
	logic [31:0] plh_s3, phl_s3;

	assign pll_c = 64'(ip_s2[31:0]) * 64'(fm_s2[31:0]);
	assign plh_c = ip_s2[31:0] * {19'b0, fm_s2[44:32]};
	assign phl_c = ip_s2[63:32] * fm_s2[31:0];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pll_s3  <= pll_c;
			plh_s3  <= plh_c;
			phl_s3  <= phl_c;
			offs_s3 <= offs_s2;
			vol_s3  <= vol_s2;
		end
	end

	// Stage 4: sum the partials and the offset fraction; keep the top phase bits.
	logic [63:0]           acc_c;
	logic [PHASE_BITS-1:0] p_s4;

	assign acc_c = pll_s3 + {plh_s3 + phl_s3, 32'b0} + {offs_s3, 48'b0};

	always_ff @(posedge clk) begin
		if (en_s4) begin
			p_s4   <= acc_c[63 -: PHASE_BITS];
			vol_s4 <= vol_s3;
		end
	end

	// Stage 5: table address for sine, direct value for the other waves.
	logic [1:0]             quad_c;
	logic [ADDR_W-1:0]      tidx_c, addr_c;
	logic [PHASE_BITS:0]    twice_c, dist_c;
	logic [PHASE_BITS+1:0]  dist2_c;
	logic signed [WAVE_W:0] tri_c, saw_c, wv_c;
	logic [MAG_W-1:0]       wmag_c;
	logic                   wneg_c;

	assign quad_c  = p_s4[PHASE_BITS-1 -: 2];
	assign tidx_c  = {1'b0, p_s4[PHASE_BITS-3 -: SINE_TABLE_BITS]};
	assign addr_c  = quad_c[0] ? (SINE_N_A - tidx_c) : tidx_c;
	assign twice_c = {p_s4, 1'b0};
	assign dist_c  = p_s4[PHASE_BITS-1] ? (twice_c - FULL_TURN) : (FULL_TURN - twice_c);
	assign dist2_c = {dist_c, 1'b0};
	assign tri_c   = $signed({1'b0, dist2_c[PHASE_BITS+1 -: WAVE_W]}) - (WAVE_W+1)'(ONE_Q16);
	assign saw_c   = $signed({2'b0, twice_c[PHASE_BITS -: MAG_W]}) - (WAVE_W+1)'(ONE_Q16);

	always_comb begin
		unique case (mode_q)
			WAVE_TRIANGLE: wv_c = tri_c;
			WAVE_SAW:      wv_c = saw_c;
			WAVE_SQUARE:   wv_c = p_s4[PHASE_BITS-1] ? -(WAVE_W+1)'(ONE_Q16)
					: (WAVE_W+1)'(ONE_Q16);
			default:       wv_c = '0;
		endcase
		wneg_c = (mode_q == WAVE_SINE) ? quad_c[1] : wv_c[WAVE_W];
		wmag_c = wv_c[WAVE_W] ? MAG_W'(-wv_c) : MAG_W'(wv_c);
	end

	logic [ADDR_W-1:0] addr_s5;
	logic              sel_s5, sel_s6;
	logic              neg_s5, neg_s6, neg_s7;
	logic [MAG_W-1:0]  wmag_s5, wmag_s6;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			addr_s5 <= addr_c;
			sel_s5  <= (mode_q == WAVE_SINE);
			neg_s5  <= wneg_c;
			wmag_s5 <= wmag_c;
			vol_s5  <= vol_s4;
		end
	end

	// Stage 6: sine ROM read with registered data.
	logic [MAG_W-1:0] sine_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			sine_s6 <= SINE_ROM[addr_s5];
			sel_s6  <= sel_s5;
			neg_s6  <= neg_s5;
			wmag_s6 <= wmag_s5;
			vol_s6  <= vol_s5;
		end
	end

	// Stage 7: wave magnitude times volume.
	logic [MAG_W-1:0]       amag_c;
	logic [MAG_W+VOL_W-1:0] prod_s7;

	assign amag_c = sel_s6 ? sine_s6 : wmag_s6;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			prod_s7 <= (MAG_W+VOL_W)'(amag_c) * (MAG_W+VOL_W)'(vol_s6);
			neg_s7  <= neg_s6;
		end
	end

	// Stage 8: round the magnitude half away from zero and apply the sign.
	logic [MAG_W+VOL_W-1:0] rnd_c;
	logic [OUT_W-1:0]       rmag_c;
	logic [OUT_W-1:0]       out_s8;

	assign rnd_c  = prod_s7 + (MAG_W+VOL_W)'(32768);
	assign rmag_c = OUT_W'(rnd_c >> 16);

	always_ff @(posedge clk) begin
		if (en_s8) begin
			out_s8 <= neg_s7 ? -rmag_c : rmag_c;
		end
	end

	assign m_axis_tdata = {(OUT_TDATA_W-OUT_W)'(0), out_s8};

	// A period register write always leaves a usable period.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_SAMPLE_PERIOD) |=>
			(period_q != '0) && (period_q <= PERIOD_MAX))
		else $error("sample period left out of range after write");

	// An accepted input occupies the first stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted input did not enter the pipeline");

	// A full stage that cannot advance keeps its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en_s4 |=> v_s4)
		else $error("stalled stage dropped its item");

	// Results never exceed four times full scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(out_s8) <= 20'sd262144) &&
			($signed(out_s8) >= -20'sd262144))
		else $error("output sample out of range");

endmodule

`default_nettype wire

// File: tb/sv/multi_waveform_oscillator_tb.sv
`default_nettype none

module multi_waveform_oscillator_tb;
	import mwo_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_BITS   = DEF_SINE_TABLE_BITS;
	localparam int TABLE_SIZE   = 1 << TABLE_BITS;
	localparam int PIPE_LATENCY = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 400;

	localparam logic [PERIOD_W-1:0] PERIOD_ALL_ONES = '1;

	typedef struct {
		logic [INDEX_W-1:0] index;
		logic [FREQ_W-1:0]  freq;
		logic [MULT_W-1:0]  mult;
		logic [OFFS_W-1:0]  offset;
		logic [VOL_W-1:0]   volume;
	} sample_req_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [0:0]             cfg_index     = REG_WAVE_MODE;
	logic [PERIOD_W-1:0]    cfg_data      = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// sample_index, note_frequency, freq_multiplier, phase_offset, volume, zero fill
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b1;
	// sample_out, zero fill
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Testbench copy of the configuration and of the quarter-wave sine ROM.
	wave_mode_t          osc_mode   = WAVE_SINE;
	logic [PERIOD_W-1:0] osc_period = PERIOD_RESET;
	logic [MAG_W-1:0]    sine_rom [0:TABLE_SIZE];

	logic [OUT_W-1:0] expected_samples [$];
	int               error_count = 0;
	int               quiet_cycles = 0;
	bit               send_gaps = 1'b1;
	bit               recv_gaps = 1'b1;

	multi_waveform_oscillator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Fill the sine ROM with a Taylor series up to the x^15 term, evaluated in Q30.
	task automatic build_sine_rom();
		logic [63:0] angle;
		logic [63:0] power;
		longint      total;
		longint      rounded;
		for (int k = 0; k <= TABLE_SIZE; k++) begin
			angle = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
			power = angle;
			total = longint'(angle);
			for (int n = 1; n <= 7; n++) begin
				power = (((power * angle) >> 30) * angle) >> 30;
				power = power / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					total = total - longint'(power);
				end else begin
					total = total + longint'(power);
				end
			end
			if (total < 0) begin
				total = 0;
			end
			rounded = (total + 8192) >>> 14;
			if (rounded > ONE_Q16) begin
				rounded = ONE_Q16;
			end
			sine_rom[k] = MAG_W'(rounded);
		end
	endtask

	// Expected output sample for one request under the current configuration.
	function automatic logic [OUT_W-1:0] oscillator_sample(sample_req_t req);
		logic [MULT_W-1:0] mult;
		logic [OFFS_W-1:0] offset;
		logic [VOL_W-1:0]  volume;
		logic [63:0]       turns;
		logic [31:0]       phase;
		logic [1:0]        quadrant;
		int                slot;
		longint            twice;
		longint            span;
		longint            wave;
		logic [63:0]       mag;
		logic [63:0]       scaled;
		mult   = (req.mult > MULT_MAX) ? MULT_MAX : req.mult;
		offset = (req.offset > OFFSET_MAX) ? OFFSET_MAX : req.offset;
		volume = (req.volume > VOLUME_MAX) ? VOLUME_MAX : req.volume;

		// The phase product is in units of 2^-64 of a turn, so only its low 64 bits matter.
		turns = 64'(req.index) * 64'(osc_period) * 64'(req.freq) * 64'(mult);
		turns = turns + (64'(offset[15:0]) << 48);
		phase = turns[63:32];

		case (osc_mode)
			WAVE_SINE: begin
				quadrant = phase[31:30];
				slot     = int'(phase[29:30-TABLE_BITS]);
				if (quadrant[0]) begin
					wave = longint'(sine_rom[TABLE_SIZE - slot]);
				end else begin
					wave = longint'(sine_rom[slot]);
				end
				if (quadrant[1]) begin
					wave = -wave;
				end
			end
			WAVE_TRIANGLE: begin
				twice = 2 * longint'({32'b0, phase});
				span  = (twice >= 64'h1_0000_0000) ? twice - 64'h1_0000_0000
					: 64'h1_0000_0000 - twice;
				wave  = ((2 * span) >>> 16) - ONE_Q16;
			end
			WAVE_SAW: begin
				wave = ((2 * longint'({32'b0, phase})) >>> 16) - ONE_Q16;
			end
			default: begin
				wave = phase[31] ? -ONE_Q16 : ONE_Q16;
			end
		endcase

		// Round the magnitude, ties away from zero, then restore the sign.
		mag    = 64'((wave < 0) ? -wave : wave) * 64'(volume);
		scaled = (mag + 64'd32768) >> 16;
		if (wave < 0) begin
			scaled = 64'd0 - scaled;
		end
		return scaled[OUT_W-1:0];
	endfunction

	// Send one request and record its expected sample once the transaction completes.
	task automatic send_sample(sample_req_t req);
		while (send_gaps && $urandom_range(0, 99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, req.volume, req.offset, req.mult, req.freq, req.index};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		expected_samples.push_back(oscillator_sample(req));
	endtask

	// Stop sending and wait until every sample in flight has come out.
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// Program both registers while the block is idle.
	task automatic apply_setting(wave_mode_t mode, logic [PERIOD_W-1:0] period);
		logic [PERIOD_W-1:0] mode_word;
		drain_pipeline();
		// Only the low two bits select the wave; the rest carries noise.
		mode_word      = PERIOD_W'({$urandom, $urandom});
		mode_word[1:0] = mode;
		cfg_we    <= 1'b1;
		cfg_index <= REG_WAVE_MODE;
		cfg_data  <= mode_word;
		@(posedge clk);
		cfg_index <= REG_SAMPLE_PERIOD;
		cfg_data  <= period;
		@(posedge clk);
		cfg_we <= 1'b0;
		osc_mode = mode;
		if (period == '0) begin
			osc_period = PERIOD_W'(1);
		end else if (period > PERIOD_MAX) begin
			osc_period = PERIOD_MAX;
		end else begin
			osc_period = period;
		end
	endtask

	function automatic sample_req_t make_req(logic [INDEX_W-1:0] index, logic [FREQ_W-1:0] freq,
			logic [MULT_W-1:0] mult, logic [OFFS_W-1:0] offset, logic [VOL_W-1:0] volume);
		sample_req_t req;
		req.index  = index;
		req.freq   = freq;
		req.mult   = mult;
		req.offset = offset;
		req.volume = volume;
		return req;
	endfunction

	// Mostly in range, sometimes any bit pattern, sometimes an end of the range.
	function automatic logic [31:0] pick_field(int unsigned width, int unsigned limit);
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			return $urandom_range(0, limit);
		end else if (sel < 85) begin
			return $urandom & ((32'd1 << width) - 1);
		end else if (sel < 93) begin
			return limit;
		end else begin
			return 0;
		end
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_period();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			return '0;
		end else if (sel < 16) begin
			return PERIOD_MAX;
		end else if (sel < 24) begin
			return PERIOD_ALL_ONES;
		end else if (sel < 60) begin
			return PERIOD_W'({$urandom, $urandom});
		end else begin
			return PERIOD_W'($urandom_range(10000000, 60000000));
		end
	endfunction

	// Extremes and out-of-range values of every field, sine wave, reset period.
	task automatic test_field_extremes();
		apply_setting(WAVE_SINE, PERIOD_RESET);
		send_sample(make_req('0, '0, '0, '0, VOLUME_MAX));
		send_sample(make_req('1, '1, MULT_MAX, '0, VOLUME_MAX));
		send_sample(make_req('1, '1, '1, '1, '1));
		send_sample(make_req('0, '1, '1, OFFSET_MAX, VOLUME_MAX));
		send_sample(make_req('0, '0, '0, OFFS_W'(16'h4000), VOL_W'(ONE_Q16)));
		send_sample(make_req('0, '0, '0, OFFS_W'(16'hC000), VOLUME_MAX));
		send_sample(make_req('1, '0, '0, OFFS_W'(16'h4000), '0));
		send_sample(make_req('0, '0, '0, OFFS_W'(16'h4000), VOL_W'(1)));
	endtask

	// Each wave at the start, middle and three quarters of a cycle.
	task automatic test_wave_shapes();
		wave_mode_t mode;
		for (int m = 0; m < 4; m++) begin
			mode = wave_mode_t'(m);
			apply_setting(mode, PERIOD_RESET);
			send_sample(make_req('0, '0, '0, '0, VOL_W'(ONE_Q16)));
			send_sample(make_req('0, '0, '0, OFFS_W'(16'h8000), VOL_W'(ONE_Q16)));
			send_sample(make_req('0, '0, '0, OFFS_W'(16'hC000), VOLUME_MAX));
		end
	endtask

	// Period register at zero, one, its limit and above its limit.
	task automatic test_period_limits();
		logic [PERIOD_W-1:0] periods [4];
		periods = '{'0, PERIOD_W'(1), PERIOD_MAX, PERIOD_ALL_ONES};
		foreach (periods[i]) begin
			apply_setting(wave_mode_t'(i), periods[i]);
			send_sample(make_req('1, '1, MULT_MAX, OFFS_W'($urandom), VOLUME_MAX));
		end
	endtask

	// Bursts of random requests under random settings, some as running sample streams.
	task automatic test_random_streams();
		int          sent;
		int          burst;
		int          burst_len;
		bit          streaming;
		sample_req_t req;
		sent  = 0;
		burst = 0;
		while (sent < RANDOM_ITEMS) begin
			apply_setting(wave_mode_t'($urandom_range(0, 3)), pick_period());
			// One long burst runs with both sides always ready.
			send_gaps = (burst != 2);
			recv_gaps = (burst != 2);
			burst_len = (burst == 2) ? 80 : $urandom_range(15, 45);
			streaming = ($urandom_range(0, 1) == 1);
			req = make_req($urandom, FREQ_W'(pick_field(FREQ_W, 24'hFFFFFF)),
				MULT_W'(pick_field(MULT_W, MULT_MAX)),
				OFFS_W'(pick_field(OFFS_W, OFFSET_MAX)),
				VOL_W'(pick_field(VOL_W, VOLUME_MAX)));
			for (int i = 0; i < burst_len; i++) begin
				if (streaming) begin
					req.index = req.index + 1;
					if ($urandom_range(0, 9) == 0) begin
						req.volume = VOL_W'(pick_field(VOL_W, VOLUME_MAX));
					end
				end else begin
					req = make_req($urandom, FREQ_W'(pick_field(FREQ_W, 24'hFFFFFF)),
						MULT_W'(pick_field(MULT_W, MULT_MAX)),
						OFFS_W'(pick_field(OFFS_W, OFFSET_MAX)),
						VOL_W'(pick_field(VOL_W, VOLUME_MAX)));
				end
				send_sample(req);
			end
			sent  = sent + burst_len;
			burst = burst + 1;
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// Random back-pressure on the output side.
	always @(posedge clk) begin
		m_axis_tready <= !(recv_gaps && $urandom_range(0, 99) < 11);
	end

	// Compare each output transaction with the oldest expected sample.
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample, expected none, actual %h",
					$time, m_axis_tdata[OUT_W-1:0]);
				error_count = error_count + 1;
			end else begin
				want = expected_samples.pop_front();
				if (m_axis_tdata[OUT_W-1:0] !== want) begin
					$display("%0t: sample_out mismatch, expected %h, actual %h",
						$time, want, m_axis_tdata[OUT_W-1:0]);
					error_count = error_count + 1;
				end
			end
		end
	end

	// End the run when neither side moves a transaction for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		build_sine_rom();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_wave_shapes();
		test_period_limits();
		test_random_streams();

		drain_pipeline();
		if (expected_samples.size() != 0) begin
			error_count = error_count + 1;
		end
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
